@@ rtl/core/gh_pkg.sv @@
// Shared constants and the character table of the geohash encoder.
package gh_pkg;

    // Bisection depth per axis for the longest code (25 + 25 bits)
    localparam int unsigned IDX_W = 25;

    // Width of the scaled offsets fed to the divide-by-45 step
    localparam int unsigned OFS_W = 31;

    // Longitude: offset to the lowest cell edge minus one, and its top clamp
    localparam logic signed [34:0] LON_OFS = 35'sd3019898879;
    localparam logic [33:0]        LON_TOP = 34'd6039797759;

    // Latitude: same, over the half-width range
    localparam logic signed [33:0] LAT_OFS = 34'sd1509949439;
    localparam logic [31:0]        LAT_TOP = 32'd3019898879;

    // Reciprocal of 45 scaled by 2^37; exact quotient for any 31-bit dividend
    localparam logic [31:0]        RECIP_45 = 32'd3054198967;
    localparam int unsigned        RECIP_SH = 37;
    localparam int unsigned        PROD_W   = OFS_W + 32;

    // Reset value of the code length register
    localparam logic [3:0]         LEN_RESET = 4'd10;

    // Map a 5-bit group to its ASCII geohash character
    function automatic logic [6:0] gh_char(input logic [4:0] sel);
        logic [6:0] ch;
        case (sel)
            5'd0:    ch = 7'h30;
            5'd1:    ch = 7'h31;
            5'd2:    ch = 7'h32;
            5'd3:    ch = 7'h33;
            5'd4:    ch = 7'h34;
            5'd5:    ch = 7'h35;
            5'd6:    ch = 7'h36;
            5'd7:    ch = 7'h37;
            5'd8:    ch = 7'h38;
            5'd9:    ch = 7'h39;
            5'd10:   ch = 7'h62;
            5'd11:   ch = 7'h63;
            5'd12:   ch = 7'h64;
            5'd13:   ch = 7'h65;
            5'd14:   ch = 7'h66;
            5'd15:   ch = 7'h67;
            5'd16:   ch = 7'h68;
            5'd17:   ch = 7'h6A;
            5'd18:   ch = 7'h6B;
            5'd19:   ch = 7'h6D;
            5'd20:   ch = 7'h6E;
            5'd21:   ch = 7'h70;
            5'd22:   ch = 7'h71;
            5'd23:   ch = 7'h72;
            5'd24:   ch = 7'h73;
            5'd25:   ch = 7'h74;
            5'd26:   ch = 7'h75;
            5'd27:   ch = 7'h76;
            5'd28:   ch = 7'h77;
            5'd29:   ch = 7'h78;
            5'd30:   ch = 7'h79;
            5'd31:   ch = 7'h7A;
            default: ch = 7'h30;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/gh_front.sv @@
// Front end: offsets, clamps and divides a coordinate pair into interleaved cell bits.
module gh_front #(
    parameter int unsigned CODE_W = 50,
    parameter int unsigned LEN_W  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_latitude,
    input  logic signed [32:0]  i_longitude,
    input  logic [LEN_W-1:0]    i_len,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CODE_W-1:0]   o_code,
    output logic [LEN_W-1:0]    o_len
);
    import gh_pkg::*;

    logic                r_a_valid;
    logic [OFS_W-1:0]    r_a_lon;
    logic [OFS_W-1:0]    r_a_lat;
    logic [LEN_W-1:0]    r_a_len;
    logic                r_b_valid;
    logic [IDX_W-1:0]    r_b_lon;
    logic [IDX_W-1:0]    r_b_lat;
    logic [LEN_W-1:0]    r_b_len;

    logic signed [34:0]  lon_u;
    logic signed [33:0]  lat_u;
    logic [33:0]         lon_c;
    logic [31:0]         lat_c;
    logic [PROD_W-1:0]   lon_prod;
    logic [PROD_W-1:0]   lat_prod;
    logic                a_adv;
    logic                b_adv;

    // Stall chain: each stage moves when the next one has room
    assign b_adv   = !r_b_valid || i_ready;
    assign a_adv   = !r_a_valid || b_adv;
    assign o_ready = a_adv;
    assign o_valid = r_b_valid;
    assign o_len   = r_b_len;

    // Shift to cell offsets and clamp out-of-range values to the end cells
    always_comb begin
        lon_u = $signed({{2{i_longitude[32]}}, i_longitude}) + LON_OFS;
        lat_u = $signed({{2{i_latitude[31]}}, i_latitude}) + LAT_OFS;
        if (lon_u[34]) begin
            lon_c = '0;
        end else if (lon_u[33:0] > LON_TOP) begin
            lon_c = LON_TOP;
        end else begin
            lon_c = lon_u[33:0];
        end
        if (lat_u[33]) begin
            lat_c = '0;
        end else if (lat_u[31:0] > LAT_TOP) begin
            lat_c = LAT_TOP;
        end else begin
            lat_c = lat_u[31:0];
        end
    end

    // Divide by 45 through the reciprocal; cell index is the quotient
    assign lon_prod = PROD_W'(r_a_lon) * PROD_W'(RECIP_45);
    assign lat_prod = PROD_W'(r_a_lat) * PROD_W'(RECIP_45);

    // Stage A: scaled offsets (clamped longitude never sets its top bit)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_adv) begin
            r_a_valid <= i_valid;
        end
        if (a_adv && i_valid) begin
            r_a_lon <= lon_c[32:2];
            r_a_lat <= lat_c[31:1];
            r_a_len <= i_len;
        end
    end

    // Stage B: registered quotients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_adv) begin
            r_b_valid <= r_a_valid;
        end
        if (b_adv && r_a_valid) begin
            r_b_lon <= lon_prod[RECIP_SH +: IDX_W];
            r_b_lat <= lat_prod[RECIP_SH +: IDX_W];
            r_b_len <= r_a_len;
        end
    end

    // Interleave, longitude first, most significant bits first
    for (genvar j = 0; j < CODE_W; j++) begin : g_mix
        if (j % 2 == 0) begin : g_lon
            assign o_code[CODE_W-1-j] = r_b_lon[IDX_W-1-j/2];
        end else begin : g_lat
            assign o_code[CODE_W-1-j] = r_b_lat[IDX_W-1-j/2];
        end
    end

endmodule

@@ rtl/core/gh_queue.sv @@
// Two-entry queue between the front end and the character serializer.
module gh_queue #(
    parameter int unsigned DATA_W = 54
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [DATA_W-1:0]  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_data
);
    logic [DATA_W-1:0] r_slot [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd];

    // Advance pointers and track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/core/gh_back.sv @@
// Back end: serializes one code word into characters behind an output register.
module gh_back #(
    parameter int unsigned CODE_W = 50,
    parameter int unsigned LEN_W  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  logic [CODE_W-1:0]  i_code,
    input  logic [LEN_W-1:0]   i_len,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_char_code,
    output logic               o_last
);
    import gh_pkg::*;

    logic               r_busy;
    logic [CODE_W-1:0]  r_code;
    logic [LEN_W-1:0]   r_left;
    logic               r_out_valid;
    logic [6:0]         r_char;
    logic               r_last;

    logic               n_busy;
    logic [CODE_W-1:0]  n_code;
    logic [LEN_W-1:0]   n_left;
    logic               n_out_valid;
    logic [6:0]         n_char;
    logic               n_last;
    logic               adv;
    logic               final_char;

    assign adv         = !r_out_valid || i_ready;
    assign final_char  = (r_left == LEN_W'(1));
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // Emit one character per free output slot; load the next word on the final one
    always_comb begin
        n_busy      = r_busy;
        n_code      = r_code;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (adv) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_char = gh_char(r_code[CODE_W-1 -: 5]);
                n_last = final_char;
                n_code = r_code << 5;
                n_left = r_left - LEN_W'(1);
            end
            if (!r_busy || final_char) begin
                o_pop  = i_valid;
                n_busy = i_valid;
                if (i_valid) begin
                    n_code = i_code;
                    n_left = i_len;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

@@ rtl/core/geohash_encoder.sv @@
// Top level of the geohash encoder: config register, front end, queue and serializer.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_ready      | i_latitude, i_longitude
//  out     | from block| o_out_valid / i_out_ready    | o_char_code, o_last
//  cfg     | to block  | i_cfg_valid / o_cfg_ready    | i_cfg_code_length
//
// An item yields one character per output transfer, code_length characters in all
// (1 to MAX_CHARS), sent one by one through the output register.
// A pair passes the offset stage, then the divide stage, before it enters the queue;
// for an idle block the serializer then loads it and registers its first character.
// Synchronous active-low reset clears all valid flags and sets the length to 10.
// Either side may stall; the two-entry queue lets the front end accept pairs till full.
module geohash_encoder #(
    parameter int unsigned MAX_CHARS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_latitude,
    input  logic signed [32:0] i_longitude,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_char_code,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_code_length
);
    import gh_pkg::*;

    localparam int unsigned CODE_W = 5 * MAX_CHARS;
    localparam int unsigned LEN_W  = $clog2(MAX_CHARS + 1);

    logic [3:0]         r_code_length;
    logic [LEN_W-1:0]   len_eff;
    logic               f_valid;
    logic               f_ready;
    logic [CODE_W-1:0]  f_code;
    logic [LEN_W-1:0]   f_len;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [CODE_W+LEN_W-1:0] q_data;

    assign o_cfg_ready = 1'b1;
    assign f_ready     = !q_full;

    // Hold the length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_code_length <= i_cfg_code_length;
        end
    end

    // Bound the length to one through MAX_CHARS
    always_comb begin
        if (r_code_length == 4'd0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_code_length) > MAX_CHARS) begin
            len_eff = LEN_W'(MAX_CHARS);
        end else begin
            len_eff = LEN_W'(r_code_length);
        end
    end

    gh_front #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_latitude  (i_latitude),
        .i_longitude (i_longitude),
        .i_len       (len_eff),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_code      (f_code),
        .o_len       (f_len)
    );

    gh_queue #(
        .DATA_W (CODE_W + LEN_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && f_ready),
        .i_data  ({f_code, f_len}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    gh_back #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_code      (q_data[CODE_W+LEN_W-1:LEN_W]),
        .i_len       (q_data[LEN_W-1:0]),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

@@ rtl/core/gh_checker.sv @@
// Port-level checks for the geohash encoder, bound to the top level.
module gh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [6:0]  o_char_code,
    input logic        o_last
);

    // Hold a stalled character transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_code) && $stable(o_last))
        else $error("output changed while stalled");

    // Only geohash alphabet characters leave the block
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_char_code >= 7'h30 && o_char_code <= 7'h39) ||
                         (o_char_code >= 7'h62 && o_char_code <= 7'h7A &&
                          o_char_code != 7'h69 && o_char_code != 7'h6C &&
                          o_char_code != 7'h6F)))
        else $error("character outside the geohash alphabet");

    // Drop the output after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind geohash_encoder gh_checker u_gh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the geohash encoder: directed table, random pairs, scoreboard.
module testbench;

    localparam int CODE_CHARS  = 10;
    localparam int N_DIRECTED  = 18;
    localparam int N_SEGMENTS  = 10;
    localparam int SEG_PAIRS   = 37;
    localparam int CYCLE_LIMIT = 400000;

    // Fixed-point bounds: degrees * 2^24
    localparam longint LAT_TOP  = 64'sd1509949440;
    localparam longint LON_TOP  = 64'sd3019898880;
    localparam longint LAT_SPAN = 64'sd3019898880;
    localparam longint LON_SPAN = 64'sd6039797760;

    localparam logic [255:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";
    localparam logic [79:0]  NO_CODE     = 80'd0;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_gh_char;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [32:0] lon;
        logic [79:0]        code;
    } t_pair_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_latitude = '0;
    logic signed [32:0] i_longitude = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [6:0]         o_char_code;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_code_length = 4'd10;

    t_gh_char   pending_chars [$];
    logic [3:0] active_len = 4'd10;
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         tx_idle_pct = 12;
    int         rx_idle_pct = 85;
    int         rx_hold_req = 0;
    int         rx_hold_left = 0;

    // Directed pairs; a typed code holds for the reset length of ten
    t_pair_row directed_rows [N_DIRECTED] = '{
        '{ 32'sd1509949440,  33'sd3019898880, "zzzzzzzzzz"},
        '{-32'sd1509949440, -33'sd3019898880, "0000000000"},
        '{ 32'sd0,           33'sd0,          "7zzzzzzzzz"},
        '{ 32'h7fffffff,     33'h100000000,   "bpbpbpbpbp"},
        '{ 32'h80000000,     33'h0ffffffff,   "pbpbpbpbpb"},
        '{ 32'h7fffffff,     33'h0ffffffff,   "zzzzzzzzzz"},
        '{ 32'h80000000,     33'h100000000,   "0000000000"},
        '{ 32'sd1509949440, -33'sd3019898880, "bpbpbpbpbp"},
        '{-32'sd1509949440,  33'sd3019898880, "pbpbpbpbpb"},
        '{-32'sd1,          -33'sd1,          NO_CODE},
        '{ 32'sd1,           33'sd1,          NO_CODE},
        '{ 32'sd1509949439, -33'sd3019898879, NO_CODE},
        '{-32'sd1509949439,  33'sd3019898879, NO_CODE},
        '{ 32'sd754974720,   33'sd1509949440, NO_CODE},
        '{-32'sd754974721,   33'sd1509949441, NO_CODE},
        '{ 32'h55555555,     33'h0aaaaaaaa,   NO_CODE},
        '{ 32'haaaaaaaa,     33'h155555555,   NO_CODE},
        '{ 32'sd819683000,   33'sd39463000,   NO_CODE}
    };

    logic [3:0] seg_len [N_SEGMENTS] = '{
        4'd1, 4'd0, 4'd15, 4'd10, 4'd5, 4'd7, 4'd3, 4'd2, 4'd9, 4'd10
    };

    geohash_encoder #(
        .MAX_CHARS(CODE_CHARS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_latitude        (i_latitude),
        .i_longitude       (i_longitude),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_char_code       (o_char_code),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_code_length (i_cfg_code_length)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Bisect both axes and queue the characters the pair must produce
    function automatic void encode_geohash(input logic signed [31:0] lat,
                                           input logic signed [32:0] lon);
        longint   lat_v, lon_v, lat_lo, lat_hi, lon_lo, lon_hi, mid;
        int       n;
        logic [4:0] bits;
        bit       odd;
        t_gh_char ch;
        lat_v  = lat;
        lon_v  = lon;
        lat_lo = -LAT_TOP;
        lat_hi = LAT_TOP;
        lon_lo = -LON_TOP;
        lon_hi = LON_TOP;
        odd    = 1'b0;
        n      = active_len;
        // Clamp the length to 1..CODE_CHARS
        if (n < 1) n = 1;
        if (n > CODE_CHARS) n = CODE_CHARS;
        for (int c = 0; c < n; c++) begin
            bits = '0;
            for (int b = 0; b < 5; b++) begin
                if (!odd) begin
                    mid  = (lon_lo + lon_hi) / 2;
                    bits = {bits[3:0], lon_v > mid};
                    if (lon_v > mid) lon_lo = mid; else lon_hi = mid;
                end else begin
                    mid  = (lat_lo + lat_hi) / 2;
                    bits = {bits[3:0], lat_v > mid};
                    if (lat_v > mid) lat_lo = mid; else lat_hi = mid;
                end
                odd = !odd;
            end
            // Low seven bits of the selected character
            ch.code = GH_ALPHABET[254 - 8*bits -: 7];
            ch.last = (c == n - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    // Pick a pair: mostly in range, some on bisection edges, some raw bit patterns
    task automatic gen_pair(output logic signed [31:0] lat, output logic signed [32:0] lon);
        int          sel, d, delta;
        longint      k, v;
        longint unsigned r;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            v   = longint'($urandom_range(0, 32'd3019898880)) - LAT_TOP;
            lat = v[31:0];
            r   = {$urandom, $urandom};
            v   = $signed(r % 64'd6039797761) - LON_TOP;
            lon = v[32:0];
        end else if (sel < 8) begin
            d     = $urandom_range(1, 25);
            k     = $urandom_range(0, 1 << d);
            delta = int'($urandom_range(0, 2)) - 1;
            v     = k * (LAT_SPAN >>> d) - LAT_TOP + delta;
            lat   = v[31:0];
            d     = $urandom_range(1, 25);
            k     = $urandom_range(0, 1 << d);
            delta = int'($urandom_range(0, 2)) - 1;
            v     = k * (LON_SPAN >>> d) - LON_TOP + delta;
            lon   = v[32:0];
        end else begin
            lat = $urandom;
            v   = {$urandom, $urandom};
            lon = v[32:0];
        end
    endtask

    // Offer one pair, hold it until the transfer, then record what it must produce
    task automatic send_pair(input logic signed [31:0] lat, input logic signed [32:0] lon,
                             input logic [79:0] typed_code);
        t_gh_char ch;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_latitude  <= lat;
        i_longitude <= lon;
        do @(posedge i_clk); while (!o_in_ready);
        if (typed_code == NO_CODE) begin
            encode_geohash(lat, lon);
        end else begin
            for (int c = 0; c < CODE_CHARS; c++) begin
                ch.code = typed_code[78 - 8*c -: 7];
                ch.last = (c == CODE_CHARS - 1);
                pending_chars.push_back(ch);
            end
        end
    endtask

    // Drop valid and wait until every queued character has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Write the code length while the block is idle
    task automatic set_code_length(input logic [3:0] len);
        wait_drained();
        i_cfg_valid       <= 1'b1;
        i_cfg_code_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_len = len;
    endtask

    // Stimulus: reset, directed table, then random segments over several lengths
    initial begin
        logic signed [31:0] lat;
        logic signed [32:0] lon;
        logic [3:0]         len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_pair(directed_rows[r].lat, directed_rows[r].lon, directed_rows[r].code);
        end

        for (int s = 0; s < N_SEGMENTS; s++) begin
            len = (s == 5 || s == 7) ? 4'($urandom_range(0, 15)) : seg_len[s];
            set_code_length(len);
            if (s < 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 85;
            end else if (s < 6) begin
                tx_idle_pct = 85;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int i = 0; i < SEG_PAIRS; i++) begin
                // Stall the output for a long stretch while pairs keep coming
                if (s == 7 && i == 5) rx_hold_req = 300;
                // Pause the sender until the block has emptied
                if (s == 8 && i == 12) wait_drained();
                gen_pair(lat, lon);
                send_pair(lat, lon, NO_CODE);
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Drive output ready: random idling, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each output transfer against the oldest queued character
    always @(posedge i_clk) begin
        t_gh_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected char expected none actual code=%h last=%b",
                         $time, o_char_code, o_last);
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code) begin
                    err_cnt++;
                    $display("%0t: char_code expected %h actual %h",
                             $time, want.code, o_char_code);
                end
                if (o_last !== want.last) begin
                    err_cnt++;
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d chars outstanding", $time, pending_chars.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/core/gh_pkg.sv
rtl/core/gh_front.sv
rtl/core/gh_queue.sv
rtl/core/gh_back.sv
rtl/core/geohash_encoder.sv
rtl/core/gh_checker.sv
verif/testbench.sv
